@@ design/abst_pkg.sv @@
// shared types and defaults for the array bst insert unit
package abst_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_KEY_BITS = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } abst_state_t;

  // handoff from descent control to the result register
  typedef struct packed {
    logic done;
    logic ovf;
  } abst_stat_t;

endpackage

@@ design/abst_ram.sv @@
// generic single-port ram with registered read
module abst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/abst_ctrl.sv @@
// descent sequencer: clear sweep, per-level node reads, final write
module abst_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32,
  localparam int SLOT_W = $clog2(CAPACITY),
  localparam int EXT_W = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     key_valid,
  output logic                     key_stall,
  input  logic [KEY_BITS-1:0]      key,
  input  logic                     order_desc,
  input  logic                     out_free,
  output logic                     ram_we,
  output logic [SLOT_W-1:0]        ram_addr,
  output logic [KEY_BITS-1:0]      ram_wdata,
  input  logic [KEY_BITS-1:0]      ram_rdata,
  output abst_pkg::abst_stat_t     stat,
  output logic [SLOT_W-1:0]        slot_res,
  output logic [EXT_W-1:0]         extent_res
);
  import abst_pkg::*;

  localparam int IDX_W = SLOT_W + 2;

  abst_state_t          state, state_next;
  logic [SLOT_W-1:0]    clr_addr, clr_addr_next;
  logic [SLOT_W-1:0]    idx, idx_next;
  logic [KEY_BITS-1:0]  key_q, key_q_next;
  logic [SLOT_W-1:0]    slot_q, slot_q_next;
  logic                 ovf_q, ovf_q_next;
  logic [EXT_W-1:0]     extent_q, extent_q_next;

  logic                 accept;
  logic                 go_left;
  logic [IDX_W-1:0]     child;
  logic                 past_end;
  logic [EXT_W-1:0]     idx_plus1;

  assign key_stall = !((state == ST_IDLE) || ((state == ST_DONE) && out_free));
  assign accept    = key_valid && !key_stall;

  // equal keys go right in either order
  assign go_left   = order_desc ? (key_q > ram_rdata) : (key_q < ram_rdata);
  assign child     = ({2'b00, idx} << 1) + (go_left ? IDX_W'(1) : IDX_W'(2));
  assign past_end  = child >= IDX_W'(CAPACITY);
  assign idx_plus1 = EXT_W'(idx) + EXT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      extent_q <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      extent_q <= extent_q_next;
    end
    idx    <= idx_next;
    key_q  <= key_q_next;
    slot_q <= slot_q_next;
    ovf_q  <= ovf_q_next;
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    idx_next      = idx;
    key_q_next    = key_q;
    slot_q_next   = slot_q;
    ovf_q_next    = ovf_q;
    extent_q_next = extent_q;
    ram_we        = 1'b0;
    ram_addr      = idx;
    ram_wdata     = key_q;
    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_addr      = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + SLOT_W'(1);
        if (clr_addr == SLOT_W'(CAPACITY - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = '0;
        if (accept) begin
          key_q_next = key;
          idx_next   = '0;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ram_rdata == '0) begin
          ram_we      = 1'b1;
          slot_q_next = idx;
          ovf_q_next  = 1'b0;
          if (extent_q < idx_plus1) begin
            extent_q_next = idx_plus1;
          end
          state_next = ST_DONE;
        end else if (past_end) begin
          slot_q_next = '0;
          ovf_q_next  = 1'b1;
          state_next  = ST_DONE;
        end else begin
          // issue the child read now so its data lands next cycle
          idx_next = child[SLOT_W-1:0];
          ram_addr = child[SLOT_W-1:0];
        end
      end
      ST_DONE: begin
        ram_addr = '0;
        if (out_free) begin
          if (accept) begin
            key_q_next = key;
            idx_next   = '0;
            state_next = ST_WALK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign stat.done  = (state == ST_DONE);
  assign stat.ovf   = ovf_q;
  assign slot_res   = slot_q;
  assign extent_res = extent_q;

endmodule

@@ design/array_bst_insert_unit.sv @@
// array bst insert unit: one node read per tree level, result register on the output
// after reset a sweep clears every slot of the node memory; key_stall stays high meanwhile
// from accept the unit reads one node per level until it finds an empty slot or runs past the
// last slot; the next item is taken in the cycle its predecessor's result is loaded
// the pace is set by the single node memory port, one registered read per level
// reset clears the ordering register to ascending and the filled extent to zero
module array_bst_insert_unit #(
  parameter int CAPACITY = abst_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = abst_pkg::DEF_KEY_BITS,
  localparam int SLOT_W = $clog2(CAPACITY),
  localparam int EXT_W = $clog2(CAPACITY + 1),
  localparam int HEIGHT_W = $clog2(SLOT_W + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                order_descending,
  input  logic                key_valid,
  output logic                key_stall,
  input  logic [KEY_BITS-1:0] key,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [SLOT_W-1:0]   slot,
  output logic                overflow,
  output logic [EXT_W-1:0]    extent,
  output logic [HEIGHT_W-1:0] tree_height
);
  import abst_pkg::*;

  logic                 order_q;
  logic                 out_free;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_addr;
  logic [KEY_BITS-1:0]  ram_wdata;
  logic [KEY_BITS-1:0]  ram_rdata;
  abst_stat_t           stat;
  logic [SLOT_W-1:0]    slot_res;
  logic [EXT_W-1:0]     extent_res;
  logic [HEIGHT_W-1:0]  height_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_q <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      order_q <= order_descending;
    end
  end

  abst_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  abst_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key        (key),
    .order_desc (order_q),
    .out_free   (out_free),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .stat       (stat),
    .slot_res   (slot_res),
    .extent_res (extent_res)
  );

  // ceil(log2(extent)): highest k with 2^k below extent, plus one
  always_comb begin
    height_res = '0;
    for (int k = 0; k < SLOT_W; k++) begin
      if ((EXT_W'(1) << k) < extent_res) begin
        height_res = HEIGHT_W'(k + 1);
      end
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stat.done && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (stat.done && out_free) begin
      slot        <= slot_res;
      overflow    <= stat.ovf;
      extent      <= extent_res;
      tree_height <= height_res;
    end
  end

`ifndef SYNTH
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    stat.done && out_free |=> result_valid)
    else $error("finished item not presented");

  a_extent_covers_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && !overflow |-> EXT_W'(slot) < extent)
    else $error("extent does not cover placed slot");

  a_overflow_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> slot == '0)
    else $error("overflow with nonzero slot");

  a_extent_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> extent <= EXT_W'(CAPACITY))
    else $error("extent beyond capacity");
`endif

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the array bst insert unit
module tb;
  import abst_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int KW = DEF_KEY_BITS;
  localparam int SLOT_W = $clog2(CAP);
  localparam int EXT_W = $clog2(CAP + 1);
  localparam int HEIGHT_W = $clog2(SLOT_W + 1);
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_N = 25;
  localparam logic ORDER_ASC = 1'b0;
  localparam logic ORDER_DESC = 1'b1;
  localparam logic [KW-1:0] KEY_EMPTY = '0;
  localparam logic [KW-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                ovf;
    logic [EXT_W-1:0]    ext;
    logic [HEIGHT_W-1:0] ht;
  } ins_result_t;

  typedef struct packed {
    logic [KW-1:0] key;
    logic          known;
    ins_result_t   res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                order_descending = 1'b0;
  logic                key_valid = 1'b0;
  logic                key_stall;
  logic [KW-1:0]       key = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [SLOT_W-1:0]   slot;
  logic                overflow;
  logic [EXT_W-1:0]    extent;
  logic [HEIGHT_W-1:0] tree_height;

  array_bst_insert_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .order_descending (order_descending),
    .key_valid        (key_valid),
    .key_stall        (key_stall),
    .key              (key),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .slot             (slot),
    .overflow         (overflow),
    .extent           (extent),
    .tree_height      (tree_height)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the tree
  logic [KW-1:0]    shadow_nodes [CAP];
  logic [EXT_W-1:0] shadow_extent = '0;
  logic             shadow_desc = 1'b0;

  ins_result_t pending_results [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          result_num = 0;

  dir_row_t      dir_rows [DIR_N];
  logic [KW-1:0] recent_keys [16];
  logic [KW-1:0] run_key = '0;
  int            run_left = 0;
  int            run_step = 0;

  function automatic logic [HEIGHT_W-1:0] height_for(logic [EXT_W-1:0] e);
    int h;
    h = 0;
    while (h < 31 && (32'd1 << h) < e) h++;
    return h[HEIGHT_W-1:0];
  endfunction

  // descend from the root and place the key in the first empty slot
  function automatic ins_result_t predict_insert(logic [KW-1:0] k);
    logic [31:0] idx;
    logic        go_left;
    logic        placed;
    ins_result_t r;
    r = '0;
    r.ovf = 1'b1;
    idx = 0;
    placed = 1'b0;
    while (idx < CAP && !placed) begin
      if (shadow_nodes[idx] == KEY_EMPTY) begin
        shadow_nodes[idx] = k;
        if (shadow_extent < idx + 1) shadow_extent = EXT_W'(idx + 1);
        r.slot = idx[SLOT_W-1:0];
        r.ovf = 1'b0;
        placed = 1'b1;
      end else begin
        go_left = shadow_desc ? (k > shadow_nodes[idx]) : (k < shadow_nodes[idx]);
        idx = go_left ? 2 * idx + 1 : 2 * idx + 2;
      end
    end
    r.ext = shadow_extent;
    r.ht = height_for(shadow_extent);
    return r;
  endfunction

  task automatic push_key(input logic [KW-1:0] k, input logic known, input ins_result_t typed);
    ins_result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key <= k;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    p = predict_insert(k);
    pending_results.push_back(known ? typed : p);
  endtask

  task automatic wait_drained();
    key_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(input logic v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    order_descending <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_desc = v;
  endtask

  task automatic report_field(input string name, input int exp_v, input int got_v);
    $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
             $time, result_num, name, exp_v, got_v);
    mismatch_count++;
  endtask

  // every caller follows this with wait_drained, which drops key_valid
  task automatic run_phase(input logic order, input int send_pct, input int rcv_pct,
                           input int n_items, input int hold_at, input int pause_at);
    logic [KW-1:0] k;
    int            r;
    write_order(order);
    send_idle_pct = send_pct;
    rcv_stall_pct <= rcv_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) hold_req <= hold_req + 1;
      if (n == pause_at) wait_drained();
      r = $urandom_range(99);
      if (run_left > 0) begin
        // monotonic runs build long chains that can end in overflow
        run_key = run_key + run_step;
        run_left--;
        k = run_key;
      end else if (r < 55) begin
        k = $urandom();
      end else if (r < 70) begin
        k = recent_keys[$urandom_range(15)];
      end else if (r < 80) begin
        k = recent_keys[$urandom_range(15)] + $urandom_range(3) - 1;
      end else if (r < 88) begin
        run_key = $urandom();
        run_step = $urandom_range(1, 1000) * (($urandom_range(1) == 1) ? 1 : -1);
        run_left = $urandom_range(4, 14);
        k = run_key;
      end else if (r < 94) begin
        k = KEY_EMPTY;
      end else if (r < 97) begin
        k = KEY_MAX;
      end else begin
        k = KW'(1) << $urandom_range(KW - 1);
      end
      recent_keys[$urandom_range(15)] = k;
      push_key(k, 1'b0, '0);
    end
  endtask

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result %0d with nothing pending: slot %0d ovf %0d extent %0d height %0d",
                 $time, result_num, slot, overflow, extent, tree_height);
        mismatch_count++;
      end else begin
        ins_result_t e;
        e = pending_results.pop_front();
        if (slot !== e.slot) report_field("slot", e.slot, slot);
        if (overflow !== e.ovf) report_field("overflow", e.ovf, overflow);
        if (extent !== e.ext) report_field("extent", e.ext, extent);
        if (tree_height !== e.ht) report_field("tree_height", e.ht, tree_height);
      end
      result_num++;
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((key_valid && !key_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** array_bst_insert_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAP; i++) shadow_nodes[i] = KEY_EMPTY;
    for (int i = 0; i < 16; i++) recent_keys[i] = $urandom();

    // key, known, slot, ovf, extent, height
    dir_rows[0]  = '{KEY_EMPTY,    1'b1, '{10'd0, 1'b0, 11'd1, 4'd0}};
    // zero key left the root empty
    dir_rows[1]  = '{32'h80000000, 1'b1, '{10'd0, 1'b0, 11'd1, 4'd0}};
    // equal key goes right
    dir_rows[2]  = '{32'h80000000, 1'b1, '{10'd2, 1'b0, 11'd3, 4'd2}};
    dir_rows[3]  = '{KEY_MAX,      1'b1, '{10'd6, 1'b0, 11'd7, 4'd3}};
    dir_rows[4]  = '{32'h40000000, 1'b0, '0};
    // left chain down to the last slot
    for (int i = 0; i < 9; i++) dir_rows[5 + i] = '{32'h20000000 >> i, 1'b0, '0};
    dir_rows[13].known = 1'b1;
    dir_rows[13].res = '{10'd1023, 1'b0, 11'd1024, 4'd10};
    dir_rows[14] = '{32'h00100000, 1'b1, '{10'd0, 1'b1, 11'd1024, 4'd10}};
    // right chain of equal max keys, then overflow
    for (int i = 15; i < 22; i++) dir_rows[i] = '{KEY_MAX, 1'b0, '0};
    dir_rows[22] = '{KEY_MAX,      1'b1, '{10'd0, 1'b1, 11'd1024, 4'd10}};
    dir_rows[23] = '{32'h55555555, 1'b0, '0};
    dir_rows[24] = '{32'hAAAAAAAA, 1'b0, '0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_order(ORDER_ASC);
    for (int i = 0; i < DIR_N; i++) push_key(dir_rows[i].key, dir_rows[i].known, dir_rows[i].res);

    run_phase(ORDER_DESC, 0, 0, 120, -1, -1);
    run_phase(ORDER_ASC, 46, 0, 120, -1, -1);
    run_phase(ORDER_DESC, 0, 46, 120, -1, -1);
    run_phase(ORDER_ASC, 35, 35, 130, -1, 60);
    run_phase(ORDER_DESC, 0, 0, 120, 10, -1);
    run_phase(ORDER_ASC, 35, 35, 120, -1, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** array_bst_insert_unit: PASSED **");
    end else begin
      $display("** array_bst_insert_unit: FAILED **");
    end
    $finish;
  end

endmodule
